@@ hw/rtl/ic3_pkg.sv @@
// Shared types and constants of the 3x3 convolution core.
package ic3_pkg;

  localparam int PIX_W      = 8;
  localparam int OUT_X_W    = 10;
  localparam int OUT_Y_W    = 16;
  localparam int FW_W       = 11;
  localparam int FH_W       = 16;
  localparam int COEF_W     = 16;
  localparam int COEF_ROW_W = 48;
  localparam int TAPS       = 3;
  localparam int WIN_N      = 9;
  localparam int MIN_DIM    = 3;
  localparam int FRAC_W     = 8;
  localparam int PROD_W     = 25;
  localparam int RSUM_W     = 27;
  localparam int SUM_W      = 29;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [FW_W-1:0]       FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0]       FRAME_HEIGHT_RST = 16'd480;
  localparam logic [COEF_ROW_W-1:0] COEF_TOP_RST     = 48'd2097152;
  localparam logic [COEF_ROW_W-1:0] COEF_MID_RST     = 48'd137443147808;
  localparam logic [COEF_ROW_W-1:0] COEF_BOT_RST     = 48'd2097152;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_COEF_TOP     = 3'd2,
    CFG_COEF_MIDDLE  = 3'd3,
    CFG_COEF_BOTTOM  = 3'd4
  } cfg_reg_t;

  typedef logic [TAPS-1:0][COEF_ROW_W-1:0] coef_rows_t;
  typedef logic [WIN_N-1:0][PIX_W-1:0]     win_px_t;

  typedef struct packed {
    win_px_t              px;
    logic [OUT_X_W-1:0]   cx;
    logic [OUT_Y_W-1:0]   cy;
    logic                 done;
  } win_item_t;

endpackage

@@ hw/rtl/ic3_in_if.sv @@
// Pixel input channel.
interface ic3_in_if;
  import ic3_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

@@ hw/rtl/ic3_out_if.sv @@
// Filtered result channel.
interface ic3_out_if;
  import ic3_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   filtered;
  logic [OUT_X_W-1:0] center_x;
  logic [OUT_Y_W-1:0] center_y;
  logic               frame_done;

  modport source (output valid, output filtered, output center_x, output center_y,
                  output frame_done, input ready);
  modport sink   (input valid, input filtered, input center_x, input center_y,
                  input frame_done, output ready);
endinterface

@@ hw/rtl/ic3_cfg_if.sv @@
// Configuration write channel.
interface ic3_cfg_if;
  import ic3_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/ic3_ram.sv @@
// Generic simple dual-port RAM with registered read.
module ic3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/ic3_cfg.sv @@
// Configuration registers and effective frame geometry.
module ic3_cfg #(
  parameter int MAX_WIDTH = 1024,
  localparam int WW = $clog2(MAX_WIDTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  ic3_cfg_if.sink                   cfg_chan,
  output logic [WW-1:0]             w_eff,
  output logic [ic3_pkg::FH_W-1:0]  h_eff,
  output ic3_pkg::coef_rows_t       coefs
);
  import ic3_pkg::*;

  localparam int FWX = (WW > FW_W) ? WW : FW_W;

  logic [FW_W-1:0]  fw_r;
  logic [FH_W-1:0]  fh_r;
  coef_rows_t       coef_r;
  logic [FWX-1:0]   fw_x;
  logic [FWX-1:0]   w_full;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r      <= FRAME_WIDTH_RST;
      fh_r      <= FRAME_HEIGHT_RST;
      coef_r[0] <= COEF_TOP_RST;
      coef_r[1] <= COEF_MID_RST;
      coef_r[2] <= COEF_BOT_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_FRAME_WIDTH:  fw_r      <= cfg_chan.data[FW_W-1:0];
        CFG_FRAME_HEIGHT: fh_r      <= cfg_chan.data[FH_W-1:0];
        CFG_COEF_TOP:     coef_r[0] <= cfg_chan.data;
        CFG_COEF_MIDDLE:  coef_r[1] <= cfg_chan.data;
        CFG_COEF_BOTTOM:  coef_r[2] <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    fw_x = FWX'(fw_r);
    priority if (fw_x < FWX'(MIN_DIM)) begin
      w_full = FWX'(MIN_DIM);
    end else if (fw_x > FWX'(MAX_WIDTH)) begin
      w_full = FWX'(MAX_WIDTH);
    end else begin
      w_full = fw_x;
    end
  end

  assign w_eff = WW'(w_full);
  assign h_eff = (fh_r < FH_W'(MIN_DIM)) ? FH_W'(MIN_DIM) : fh_r;
  assign coefs = coef_r;

endmodule

@@ hw/rtl/ic3_line.sv @@
// Position counters, line store read-modify-write and 3x3 window.
module ic3_line #(
  parameter int MAX_WIDTH = 1024,
  localparam int WW = $clog2(MAX_WIDTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  ic3_in_if.sink                   in_chan,
  input  logic [WW-1:0]            w_eff,
  input  logic [ic3_pkg::FH_W-1:0] h_eff,
  output logic                     win_valid,
  input  logic                     win_ready,
  output ic3_pkg::win_item_t       win_item
);
  import ic3_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int LW = 2 * PIX_W;

  logic [CW-1:0]     col_r, col_nxt;
  logic [FH_W-1:0]   row_r, row_nxt;
  logic [CW-1:0]     col0, x;
  logic [FH_W-1:0]   row0, y;
  logic [FH_W:0]     row1;
  logic              wrap_c, last_col, last_row, emit, done;
  logic              accept;

  logic              s1_v_r;
  logic [CW-1:0]     s1_x_r;
  logic [PIX_W-1:0]  s1_pix_r;
  logic              s1_emit_r, s1_done_r;
  logic [OUT_X_W-1:0] s1_cx_r;
  logic [OUT_Y_W-1:0] s1_cy_r;
  logic              s1_mv;

  logic [LW-1:0]     ram_rdata, ld_word, wdata;
  logic              fwd_r;
  logic [LW-1:0]     fwd_word_r;
  logic              fwd_hit;

  win_px_t           win_r, win_nxt;

  always_comb begin
    col0     = in_chan.frame_start ? '0 : col_r;
    row0     = in_chan.frame_start ? '0 : row_r;
    wrap_c   = WW'(col0) >= w_eff;
    row1     = wrap_c ? ({1'b0, row0} + (FH_W+1)'(1)) : {1'b0, row0};
    x        = wrap_c ? '0 : col0;
    y        = (row1 >= {1'b0, h_eff}) ? '0 : row1[FH_W-1:0];
    last_col = (WW'(x) + WW'(1)) >= w_eff;
    last_row = ({1'b0, y} + (FH_W+1)'(1)) >= {1'b0, h_eff};
    emit     = (x >= CW'(2)) && (y >= FH_W'(2));
    done     = last_col && last_row;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : y + FH_W'(1);
    end else begin
      col_nxt = CW'(WW'(x) + WW'(1));
      row_nxt = y;
    end
  end

  assign s1_mv         = s1_v_r && (!s1_emit_r || win_ready);
  assign in_chan.ready = !s1_v_r || s1_mv;
  assign accept        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else begin
      if (accept) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        s1_v_r <= 1'b1;
        fwd_r  <= fwd_hit;
      end else if (s1_mv) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x_r     <= x;
      s1_pix_r   <= in_chan.pixel;
      s1_emit_r  <= emit;
      s1_done_r  <= done;
      s1_cx_r    <= OUT_X_W'(x - CW'(1));
      s1_cy_r    <= y - FH_W'(1);
      fwd_word_r <= wdata;
    end
    if (s1_mv) begin
      win_r <= win_nxt;
    end
  end

  // same entry written and read at one edge: take the write data
  assign fwd_hit = s1_mv && (s1_x_r == x);
  assign ld_word = fwd_r ? fwd_word_r : ram_rdata;
  assign wdata   = {ld_word[PIX_W-1:0], s1_pix_r};

  ic3_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_mv),
    .waddr (s1_x_r),
    .wdata (wdata),
    .re    (accept),
    .raddr (x),
    .rdata (ram_rdata)
  );

  always_comb begin
    for (int r = 0; r < TAPS; r++) begin
      win_nxt[r*TAPS]     = win_r[r*TAPS + 1];
      win_nxt[r*TAPS + 1] = win_r[r*TAPS + 2];
    end
    win_nxt[2] = ld_word[LW-1:PIX_W];
    win_nxt[5] = ld_word[PIX_W-1:0];
    win_nxt[8] = s1_pix_r;
  end

  assign win_valid     = s1_v_r && s1_emit_r;
  assign win_item.px   = win_nxt;
  assign win_item.cx   = s1_cx_r;
  assign win_item.cy   = s1_cy_r;
  assign win_item.done = s1_done_r;

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_v_r)
    else $error("accepted item missing from line stage");

  a_fwd_set: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && s1_mv && (s1_x_r == x)) |=> fwd_r)
    else $error("line store forwarding not armed");

  a_emit_col: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_emit_r) |-> (s1_x_r >= CW'(2)))
    else $error("result item for a border column");

endmodule

@@ hw/rtl/ic3_mac.sv @@
// Nine-tap multiply, row sums and saturating output stage.
module ic3_mac (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 win_valid,
  output logic                 win_ready,
  input  ic3_pkg::win_item_t   win_item,
  input  ic3_pkg::coef_rows_t  coefs,
  ic3_out_if.source            out_chan
);
  import ic3_pkg::*;

  logic                     s2_v_r, s3_v_r, o_v_r;
  logic                     out_free, s3_free, s2_free;
  logic signed [PROD_W-1:0] prod_nxt [WIN_N];
  logic signed [PROD_W-1:0] prod_r   [WIN_N];
  logic signed [RSUM_W-1:0] rsum_nxt [TAPS];
  logic signed [RSUM_W-1:0] rsum_r   [TAPS];
  logic signed [SUM_W-1:0]  total;
  logic [PIX_W-1:0]         sat;
  logic [OUT_X_W-1:0]       s2_cx_r, s3_cx_r, o_cx_r;
  logic [OUT_Y_W-1:0]       s2_cy_r, s3_cy_r, o_cy_r;
  logic                     s2_done_r, s3_done_r, o_done_r;
  logic [PIX_W-1:0]         o_pix_r;

  assign out_free  = !o_v_r || out_chan.ready;
  assign s3_free   = !s3_v_r || out_free;
  assign s2_free   = !s2_v_r || s3_free;
  assign win_ready = s2_free;

  always_comb begin
    for (int r = 0; r < TAPS; r++) begin
      for (int k = 0; k < TAPS; k++) begin
        prod_nxt[r*TAPS + k] = PROD_W'($signed(coefs[r][k*COEF_W +: COEF_W]))
                             * PROD_W'($signed({1'b0, win_item.px[r*TAPS + k]}));
      end
    end
  end

  always_comb begin
    for (int r = 0; r < TAPS; r++) begin
      rsum_nxt[r] = RSUM_W'(prod_r[r*TAPS]) + RSUM_W'(prod_r[r*TAPS + 1])
                  + RSUM_W'(prod_r[r*TAPS + 2]);
    end
  end

  always_comb begin
    total = SUM_W'(rsum_r[0]) + SUM_W'(rsum_r[1]) + SUM_W'(rsum_r[2]);
    priority if (total[SUM_W-1]) begin
      sat = '0;
    end else if (|total[SUM_W-2:FRAC_W+PIX_W]) begin
      sat = '1;
    end else begin
      sat = total[FRAC_W+PIX_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (s2_free) begin
        s2_v_r <= win_valid;
      end
      if (s3_free) begin
        s3_v_r <= s2_v_r;
      end
      if (out_free) begin
        o_v_r <= s3_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (win_valid && s2_free) begin
      prod_r    <= prod_nxt;
      s2_cx_r   <= win_item.cx;
      s2_cy_r   <= win_item.cy;
      s2_done_r <= win_item.done;
    end
    if (s2_v_r && s3_free) begin
      rsum_r    <= rsum_nxt;
      s3_cx_r   <= s2_cx_r;
      s3_cy_r   <= s2_cy_r;
      s3_done_r <= s2_done_r;
    end
    if (s3_v_r && out_free) begin
      o_pix_r  <= sat;
      o_cx_r   <= s3_cx_r;
      o_cy_r   <= s3_cy_r;
      o_done_r <= s3_done_r;
    end
  end

  assign out_chan.valid      = o_v_r;
  assign out_chan.filtered   = o_pix_r;
  assign out_chan.center_x   = o_cx_r;
  assign out_chan.center_y   = o_cy_r;
  assign out_chan.frame_done = o_done_r;

  a_win_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (win_valid && win_ready) |=> s2_v_r)
    else $error("window item lost at product stage");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !s3_free) |=> (s2_v_r && $stable(s2_cx_r) && $stable(s2_cy_r)))
    else $error("product stage changed while stalled");

  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && !out_free) |=> (s3_v_r && $stable(s3_cx_r)))
    else $error("sum stage dropped an item");

endmodule

@@ hw/rtl/image_convolution_3x3_core.sv @@
// Top level of the streaming 3x3 convolution core.
// A result is held in the line, product, row-sum and output registers before out_chan.
// Throughput: one pixel per cycle unless out_chan stalls; the line store is one 16-bit RAM read
// at accept, written as its item leaves the line stage; a forwarding register covers back-to-back hits.
// Reset (synchronous, rst_n low): registers to defaults, counters to zero; no RAM clear.
module image_convolution_3x3_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  ic3_in_if.sink      in_chan,
  ic3_out_if.source   out_chan,
  ic3_cfg_if.sink     cfg_chan
);
  import ic3_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [WW-1:0]   w_eff;
  logic [FH_W-1:0] h_eff;
  coef_rows_t      coefs;
  logic            win_valid;
  logic            win_ready;
  win_item_t       win_item;

  ic3_cfg #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .coefs    (coefs)
  );

  ic3_line #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win_item  (win_item)
  );

  ic3_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win_item  (win_item),
    .coefs     (coefs),
    .out_chan  (out_chan)
  );

endmodule

@@ verif/image_convolution_3x3_core_tb.sv @@
// Self-checking testbench of the 3x3 convolution core: directed frames, then randomised frames.
module image_convolution_3x3_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ic3_pkg::*;

  localparam int CYCLE_LIMIT  = 500_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1400;
  localparam int MAX_COLS     = 1024;
  localparam int DIR_N        = 22;

  localparam logic [COEF_W-1:0] Q_MAX = 16'h7FFF;
  localparam logic [COEF_W-1:0] Q_MIN = 16'h8000;

  typedef struct packed {
    logic [PIX_W-1:0]   filtered;
    logic [OUT_X_W-1:0] cx;
    logic [OUT_Y_W-1:0] cy;
    logic               done;
  } conv_out_t;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic             start;
    logic             known;
    conv_out_t        want;
  } pix_row_t;

  localparam conv_out_t NO_OUT    = '0;
  localparam conv_out_t BLUR_FULL = '{8'd191, 10'd1, 16'd1, 1'b1};
  localparam conv_out_t ZERO_DONE = '{8'd0, 10'd1, 16'd1, 1'b1};

  pix_row_t dir_tab [DIR_N] = '{
    '{8'hFF, 1'b1, 1'b0, NO_OUT}, '{8'hFF, 1'b0, 1'b0, NO_OUT}, '{8'hFF, 1'b0, 1'b0, NO_OUT},
    '{8'hFF, 1'b0, 1'b0, NO_OUT}, '{8'hFF, 1'b0, 1'b0, NO_OUT}, '{8'hFF, 1'b0, 1'b0, NO_OUT},
    '{8'hFF, 1'b0, 1'b0, NO_OUT}, '{8'hFF, 1'b0, 1'b0, NO_OUT}, '{8'hFF, 1'b0, 1'b1, BLUR_FULL},
    '{8'h55, 1'b0, 1'b0, NO_OUT}, '{8'hAA, 1'b0, 1'b0, NO_OUT}, '{8'h0F, 1'b0, 1'b0, NO_OUT},
    '{8'hF0, 1'b0, 1'b0, NO_OUT},
    '{8'h00, 1'b1, 1'b0, NO_OUT}, '{8'h00, 1'b0, 1'b0, NO_OUT}, '{8'h00, 1'b0, 1'b0, NO_OUT},
    '{8'h00, 1'b0, 1'b0, NO_OUT}, '{8'h00, 1'b0, 1'b0, NO_OUT}, '{8'h00, 1'b0, 1'b0, NO_OUT},
    '{8'h00, 1'b0, 1'b0, NO_OUT}, '{8'h00, 1'b0, 1'b0, NO_OUT}, '{8'h00, 1'b0, 1'b1, ZERO_DONE}
  };

  logic clk;
  logic rst_n;

  ic3_in_if  in_chan ();
  ic3_out_if out_chan ();
  ic3_cfg_if cfg_chan ();

  image_convolution_3x3_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  logic [FW_W-1:0]       reg_width  = FRAME_WIDTH_RST;
  logic [FH_W-1:0]       reg_height = FRAME_HEIGHT_RST;
  logic [COEF_ROW_W-1:0] kernel_row [TAPS] = '{COEF_TOP_RST, COEF_MID_RST, COEF_BOT_RST};
  logic [PIX_W-1:0]      row_above [MAX_COLS] = '{default: '0};
  logic [PIX_W-1:0]      row_prev  [MAX_COLS] = '{default: '0};
  logic [PIX_W-1:0]      win [WIN_N] = '{default: '0};
  int                    col_pos = 0;
  int                    row_pos = 0;

  conv_out_t expected_out [$];
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  int        mismatches     = 0;
  int        cycle_cnt      = 0;
  bit        restart_due    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_width();
    int w;
    w = reg_width;
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > MAX_COLS) w = MAX_COLS;
    return w;
  endfunction

  function automatic bit convolve_pixel(input logic [PIX_W-1:0] px, input logic fs,
                                        output conv_out_t res);
    int     w, h, x, y;
    longint acc, q;
    w = eff_width();
    h = (reg_height < MIN_DIM) ? MIN_DIM : int'(reg_height);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    x = col_pos;
    y = row_pos;
    for (int r = 0; r < TAPS; r++) begin
      win[r*TAPS]   = win[r*TAPS+1];
      win[r*TAPS+1] = win[r*TAPS+2];
    end
    win[2] = row_above[x];
    win[5] = row_prev[x];
    win[8] = px;
    row_above[x] = row_prev[x];
    row_prev[x]  = px;
    res = '0;
    convolve_pixel = 1'b0;
    if (x >= 2 && y >= 2) begin
      acc = 0;
      for (int r = 0; r < TAPS; r++)
        for (int k = 0; k < TAPS; k++)
          acc += longint'($signed(kernel_row[r][COEF_W*k +: COEF_W])) *
                 longint'(win[r*TAPS+k]);
      if (acc < 0) begin
        res.filtered = '0;
      end else begin
        q = acc >>> FRAC_W;
        res.filtered = (q > 255) ? 8'd255 : q[PIX_W-1:0];
      end
      res.cx   = OUT_X_W'(x - 1);
      res.cy   = OUT_Y_W'(y - 1);
      res.done = (x == w - 1) && (y == h - 1);
      convolve_pixel = 1'b1;
    end
    if (x + 1 >= w) begin
      col_pos = 0;
      row_pos = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
    end
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [COEF_ROW_W-1:0] rand_kernel_row();
    logic [COEF_ROW_W-1:0] row;
    logic [COEF_W-1:0]     tap;
    for (int k = 0; k < TAPS; k++) begin
      case ($urandom_range(7))
        0:       tap = Q_MAX;
        1:       tap = Q_MIN;
        2:       tap = '0;
        3:       tap = COEF_W'($urandom);
        default: tap = COEF_W'($urandom_range(160)) - COEF_W'(64);
      endcase
      row[COEF_W*k +: COEF_W] = tap;
    end
    return row;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= d;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    case (cfg_reg_t'(idx))
      CFG_FRAME_WIDTH:  reg_width     = d[FW_W-1:0];
      CFG_FRAME_HEIGHT: reg_height    = d[FH_W-1:0];
      CFG_COEF_TOP:     kernel_row[0] = d;
      CFG_COEF_MIDDLE:  kernel_row[1] = d;
      CFG_COEF_BOTTOM:  kernel_row[2] = d;
      default: ;
    endcase
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(input int w, input int h);
    logic [CFG_DATA_W-1:0] d;
    int                    old_w;
    old_w = eff_width();
    d = rand48();
    d[FW_W-1:0] = FW_W'(w);
    write_reg(CFG_FRAME_WIDTH, d);
    d = rand48();
    d[FH_W-1:0] = FH_W'(h);
    write_reg(CFG_FRAME_HEIGHT, d);
    if (eff_width() > old_w) restart_due = 1'b1;
  endtask

  task automatic set_kernel(input logic [COEF_ROW_W-1:0] t, input logic [COEF_ROW_W-1:0] m,
                            input logic [COEF_ROW_W-1:0] b);
    write_reg(CFG_COEF_TOP, t);
    write_reg(CFG_COEF_MIDDLE, m);
    write_reg(CFG_COEF_BOTTOM, b);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs, input logic known,
                            input conv_out_t want);
    conv_out_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.pixel       <= px;
    in_chan.frame_start <= fs;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    if (convolve_pixel(px, fs, pred)) expected_out.push_back(known ? want : pred);
  endtask

  task automatic run_pixels(input int n, input bit clean);
    logic [PIX_W-1:0] px;
    logic             fs;
    for (int i = 0; i < n; i++) begin
      fs = (col_pos == 0 && row_pos == 0) && ($urandom_range(9) != 0);
      if (!clean && $urandom_range(49) == 0) fs = 1'b1;
      if (restart_due) begin
        fs = 1'b1;
        restart_due = 1'b0;
      end
      case ($urandom_range(9))
        0:       px = '0;
        1:       px = '1;
        default: px = PIX_W'($urandom);
      endcase
      send_pixel(px, fs, 1'b0, NO_OUT);
    end
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    conv_out_t want;
    out_chan.ready <= 1'b0;
    while (cycle_cnt <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
      if (rst_n && out_chan.valid && out_chan.ready) begin
        if (expected_out.size() == 0) begin
          $display("%0t: unexpected item filtered %0d at (%0d,%0d)", $time,
                   out_chan.filtered, out_chan.center_x, out_chan.center_y);
          mismatches++;
        end else begin
          want = expected_out.pop_front();
          check_field("filtered", want.filtered, out_chan.filtered);
          check_field("center_x", want.cx, out_chan.center_x);
          check_field("center_y", want.cy, out_chan.center_y);
          check_field("frame_done", want.done, out_chan.frame_done);
        end
      end
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
    $display("FAIL image_convolution_3x3_core");
    $finish;
  end

  initial begin
    int w, h, n, rnd_items;
    rnd_items = 0;
    in_chan.valid       <= 1'b0;
    in_chan.pixel       <= '0;
    in_chan.frame_start <= 1'b0;
    cfg_chan.valid      <= 1'b0;
    cfg_chan.index      <= CFG_FRAME_WIDTH;
    cfg_chan.data       <= '0;
    rst_n               <= 1'b0;
    send_idle_pct  = 14;
    recv_stall_pct = 72;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_frame(3, 3);
    foreach (dir_tab[i])
      send_pixel(dir_tab[i].px, dir_tab[i].start, dir_tab[i].known, dir_tab[i].want);
    drain();

    for (int i = int'(CFG_COEF_BOTTOM) + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), rand48());

    set_frame(0, 0);
    set_kernel({3{Q_MAX}}, {3{Q_MAX}}, {3{Q_MAX}});
    run_pixels(60, 1'b0);
    drain();
    set_frame(4, 65535);
    set_kernel({3{Q_MIN}}, {3{Q_MIN}}, {3{Q_MIN}});
    run_pixels(60, 1'b0);
    drain();
    set_frame(8, 6);
    set_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
    run_pixels(31, 1'b1);
    drain();
    set_frame(5, 5);
    run_pixels(60, 1'b0);
    drain();
    rnd_items = 211;

    while (rnd_items < RANDOM_ITEMS) begin
      if (rnd_items < RANDOM_ITEMS / 3) begin
        send_idle_pct  = 14;
        recv_stall_pct = 72;
      end else if (rnd_items < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct  = 72;
        recv_stall_pct = 14;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      case ($urandom_range(19))
        0, 1:    w = $urandom_range(0, 2);
        2:       w = $urandom_range(13, 64);
        default: w = $urandom_range(3, 12);
      endcase
      case ($urandom_range(29))
        0:       h = 65535;
        1, 2:    h = $urandom_range(0, 2);
        3, 4, 5: h = $urandom_range(9, 20);
        default: h = $urandom_range(3, 8);
      endcase
      set_frame(w, h);
      if ($urandom_range(4) == 0)
        set_kernel(COEF_TOP_RST, COEF_MID_RST, COEF_BOT_RST);
      else
        set_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
      n = $urandom_range(40, 160);
      run_pixels(n, 1'b0);
      rnd_items += n;
      drain();
    end

    if (mismatches == 0)
      $display("PASS image_convolution_3x3_core");
    else
      $display("FAIL image_convolution_3x3_core");
    $finish;
  end

endmodule
